[rtl/core/skfd_pkg.sv]
`default_nettype none

package skfd_pkg;

    // FIFO geometry
    localparam int FIFO_DEPTH = 32;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int COUNT_W    = 6;

    // scan-code set 1 bytes
    localparam logic [7:0] SC_EXT       = 8'hE0;
    localparam logic [7:0] SC_LSHIFT    = 8'h2A;
    localparam logic [7:0] SC_RSHIFT    = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BR = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BR = 8'hB6;
    localparam logic [7:0] SC_CAPS      = 8'h3A;
    localparam logic [7:0] SC_TAB       = 8'h0F;
    localparam logic [7:0] SC_UP        = 8'h48;
    localparam logic [7:0] SC_DOWN      = 8'h50;
    localparam logic [7:0] SC_LEFT      = 8'h4B;
    localparam logic [7:0] SC_RIGHT     = 8'h4D;

    // arrow tokens
    localparam logic [7:0] TOK_UP    = 8'hF1;
    localparam logic [7:0] TOK_DOWN  = 8'hF2;
    localparam logic [7:0] TOK_LEFT  = 8'hF3;
    localparam logic [7:0] TOK_RIGHT = 8'hF4;

    typedef enum logic [1:0] {
        MODE_SCAN     = 2'd0,
        MODE_POP      = 2'd1,
        MODE_CLEAR    = 2'd2,
        MODE_FLAG_CLR = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] scan_byte;
        logic       snapshot_enable;
    } cmd_t;

    typedef struct packed {
        logic               key_valid;
        logic [7:0]         key_char;
        logic [7:0]         key_scan;
        logic               key_pressed;
        logic [COUNT_W-1:0] fifo_count;
        logic               snapshot_saved;
        logic               snapshot_request;
    } evt_t;

    // one queued key event
    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] scan;
        logic       pressed;
    } entry_t;

    // decoder result for one step
    typedef struct packed {
        logic   push;
        entry_t entry;
        logic   snap_req;
        logic   saved;
    } dec_t;

    // per-cell control
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    // lower-case table
    function automatic logic [7:0] lower_char(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'h01: ch = 8'h1B;
            7'h02: ch = 8'h31;
            7'h03: ch = 8'h32;
            7'h04: ch = 8'h33;
            7'h05: ch = 8'h34;
            7'h06: ch = 8'h35;
            7'h07: ch = 8'h36;
            7'h08: ch = 8'h37;
            7'h09: ch = 8'h38;
            7'h0A: ch = 8'h39;
            7'h0B: ch = 8'h30;
            7'h0C: ch = 8'h2D;
            7'h0D: ch = 8'h3D;
            7'h0E: ch = 8'h08;
            7'h0F: ch = 8'h09;
            7'h10: ch = 8'h71;
            7'h11: ch = 8'h77;
            7'h12: ch = 8'h65;
            7'h13: ch = 8'h72;
            7'h14: ch = 8'h74;
            7'h15: ch = 8'h79;
            7'h16: ch = 8'h75;
            7'h17: ch = 8'h69;
            7'h18: ch = 8'h6F;
            7'h19: ch = 8'h70;
            7'h1A: ch = 8'h5B;
            7'h1B: ch = 8'h5D;
            7'h1C: ch = 8'h0A;
            7'h1E: ch = 8'h61;
            7'h1F: ch = 8'h73;
            7'h20: ch = 8'h64;
            7'h21: ch = 8'h66;
            7'h22: ch = 8'h67;
            7'h23: ch = 8'h68;
            7'h24: ch = 8'h6A;
            7'h25: ch = 8'h6B;
            7'h26: ch = 8'h6C;
            7'h27: ch = 8'h3B;
            7'h28: ch = 8'h27;
            7'h29: ch = 8'h60;
            7'h2B: ch = 8'h5C;
            7'h2C: ch = 8'h7A;
            7'h2D: ch = 8'h78;
            7'h2E: ch = 8'h63;
            7'h2F: ch = 8'h76;
            7'h30: ch = 8'h62;
            7'h31: ch = 8'h6E;
            7'h32: ch = 8'h6D;
            7'h33: ch = 8'h2C;
            7'h34: ch = 8'h2E;
            7'h35: ch = 8'h2F;
            7'h37: ch = 8'h2A;
            7'h39: ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // caps-lock table: letters upper case, digits and punctuation dropped
    function automatic logic [7:0] upper_char(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'h01: ch = 8'h1B;
            7'h0E: ch = 8'h08;
            7'h0F: ch = 8'h09;
            7'h10: ch = 8'h51;
            7'h11: ch = 8'h57;
            7'h12: ch = 8'h45;
            7'h13: ch = 8'h52;
            7'h14: ch = 8'h54;
            7'h15: ch = 8'h59;
            7'h16: ch = 8'h55;
            7'h17: ch = 8'h49;
            7'h18: ch = 8'h4F;
            7'h19: ch = 8'h50;
            7'h1C: ch = 8'h0A;
            7'h1E: ch = 8'h41;
            7'h1F: ch = 8'h53;
            7'h20: ch = 8'h44;
            7'h21: ch = 8'h46;
            7'h22: ch = 8'h47;
            7'h23: ch = 8'h48;
            7'h24: ch = 8'h4A;
            7'h25: ch = 8'h4B;
            7'h26: ch = 8'h4C;
            7'h2C: ch = 8'h5A;
            7'h2D: ch = 8'h58;
            7'h2E: ch = 8'h43;
            7'h2F: ch = 8'h56;
            7'h30: ch = 8'h42;
            7'h31: ch = 8'h4E;
            7'h32: ch = 8'h4D;
            7'h39: ch = 8'h20;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

[rtl/core/skfd_decode.sv]
`default_nettype none

module skfd_decode (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire skfd_pkg::cmd_t  cmd,
    output skfd_pkg::dec_t       dec
);
    import skfd_pkg::*;

    logic prefix_reg, prefix_next;
    logic shift_reg, shift_next;
    logic caps_reg, caps_next;
    logic saved_reg, saved_next;
    logic [7:0] b;
    logic [7:0] ch;
    logic       push;
    logic       snap_req;

    assign b = cmd.scan_byte;

    // byte decode and modifier tracking
    always_comb
    begin
        prefix_next = prefix_reg;
        shift_next  = shift_reg;
        caps_next   = caps_reg;
        saved_next  = saved_reg;
        ch          = 8'h00;
        push        = 1'b0;
        snap_req    = 1'b0;
        if (accept && cmd.mode == MODE_SCAN)
        begin
            if (b == SC_EXT)
            begin
                prefix_next = 1'b1;
            end
            else if (prefix_reg)
            begin
                prefix_next = 1'b0;
                if (!b[7])
                begin
                    case (b)
                        SC_UP:    ch = TOK_UP;
                        SC_DOWN:  ch = TOK_DOWN;
                        SC_LEFT:  ch = TOK_LEFT;
                        SC_RIGHT: ch = TOK_RIGHT;
                        default:  ch = 8'h00;
                    endcase
                    push = (ch != 8'h00);
                end
            end
            else if (b == SC_LSHIFT || b == SC_RSHIFT)
            begin
                shift_next = 1'b1;
            end
            else if (b == SC_LSHIFT_BR || b == SC_RSHIFT_BR)
            begin
                shift_next = 1'b0;
            end
            else if (b == SC_CAPS)
            begin
                caps_next = !caps_reg;
            end
            else if (b == SC_TAB && shift_reg && cmd.snapshot_enable)
            begin
                saved_next = 1'b1;
                snap_req   = 1'b1;
            end
            else if (!b[7])
            begin
                ch   = caps_reg ? upper_char(b[6:0]) : lower_char(b[6:0]);
                push = (ch != 8'h00);
            end
        end
        if (accept && cmd.mode == MODE_FLAG_CLR)
        begin
            saved_next = 1'b0;
        end
    end

    always_comb
    begin
        dec.push          = push;
        dec.entry.ch      = ch;
        dec.entry.scan    = b;
        dec.entry.pressed = 1'b1;
        dec.snap_req      = snap_req;
        dec.saved         = saved_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= 1'b0;
            shift_reg  <= 1'b0;
            caps_reg   <= 1'b0;
            saved_reg  <= 1'b0;
        end
        else
        begin
            prefix_reg <= prefix_next;
            shift_reg  <= shift_next;
            caps_reg   <= caps_next;
            saved_reg  <= saved_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/skfd_cell.sv]
`default_nettype none

module skfd_cell (
    input  wire logic                 clk,
    input  wire skfd_pkg::cell_ctrl_t ctrl,
    input  wire skfd_pkg::entry_t     neighbor,
    input  wire skfd_pkg::entry_t     fresh,
    output skfd_pkg::entry_t          entry
);
    import skfd_pkg::*;

    entry_t entry_reg, entry_next;

    // a new key wins over the shift from the neighbor
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            entry_next = fresh;
        end
        else if (ctrl.shift)
        begin
            entry_next = neighbor;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

[rtl/core/skfd_chain.sv]
`default_nettype none

module skfd_chain (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire skfd_pkg::mode_t             mode,
    input  wire logic                        push,
    input  wire skfd_pkg::entry_t            fresh,
    output skfd_pkg::entry_t                 head,
    output logic                             pop_ok,
    output logic [skfd_pkg::CNT_W-1:0]       count_after
);
    import skfd_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             full;
    logic             do_push;
    logic             shift_all;
    entry_t           cell_q [FIFO_DEPTH];
    cell_ctrl_t       ctrl   [FIFO_DEPTH];

    assign full    = (count_reg == CNT_W'(FIFO_DEPTH));
    assign do_push = accept && mode == MODE_SCAN && push;
    assign pop_ok  = accept && mode == MODE_POP && count_reg != '0;
    // pop, or push over the oldest word: everything moves one cell toward the head
    assign shift_all = pop_ok || (do_push && full);

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            case (mode)
                MODE_SCAN:
                begin
                    if (do_push && !full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                MODE_POP:
                begin
                    if (pop_ok)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                MODE_CLEAR:    count_next = '0;
                MODE_FLAG_CLR: count_next = count_reg;
                default:       count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // row of cells, cell 0 holds the oldest word
    for (genvar i = 0; i < FIFO_DEPTH; i++)
    begin : g_cell
        always_comb
        begin
            ctrl[i].shift = shift_all;
            ctrl[i].load  = do_push &&
                            (full ? (i == FIFO_DEPTH - 1) : (count_reg == CNT_W'(i)));
        end

        if (i < FIFO_DEPTH - 1)
        begin : g_mid
            skfd_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl[i]),
                .neighbor (cell_q[i+1]),
                .fresh    (fresh),
                .entry    (cell_q[i])
            );
        end
        else
        begin : g_last
            skfd_cell u_cell (
                .clk      (clk),
                .ctrl     (ctrl[i]),
                .neighbor (fresh),
                .fresh    (fresh),
                .entry    (cell_q[i])
            );
        end
    end

    assign head        = cell_q[0];
    assign count_after = count_next;

endmodule

`default_nettype wire

[rtl/core/scancode_key_decoder_fifo_top.sv]
`default_nettype none

// Set-1 keyboard decoder with a 32-word key queue. Each command word (scan byte,
// pop, queue clear, snapshot-flag clear) is taken back to back, one per clock,
// while cmd_stall is low. Its result word is registered in the output buffer
// and shown on evt. If the output word is still held by evt_stall, the result
// waits in the buffer until the words ahead of it are taken. The queue is a row
// of 32 shift cells with the oldest key in cell 0, so a pop or an overwrite of
// the oldest key moves every cell one place in the same cycle. A two-word output
// buffer keeps cmd flowing while a result waits: cmd_stall rises only when both
// buffer words are full. No clearing pass after reset.
module scancode_key_decoder_fifo_top (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cmd_valid,
    output logic                 cmd_stall,
    input  wire skfd_pkg::cmd_t  cmd,
    output logic                 evt_valid,
    input  wire logic            evt_stall,
    output skfd_pkg::evt_t       evt
);
    import skfd_pkg::*;

    logic             accept;
    logic             take;
    dec_t             dec;
    entry_t           head;
    logic             pop_ok;
    logic [CNT_W-1:0] count_after;
    evt_t             res;

    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    evt_t out_reg, out_next;
    evt_t skid_reg, skid_next;

    assign cmd_stall = skid_valid_reg;
    assign accept    = cmd_valid && !cmd_stall;
    assign take      = out_valid_reg && !evt_stall;

    skfd_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .accept(accept),
        .cmd   (cmd),
        .dec   (dec)
    );

    skfd_chain u_chain (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (cmd.mode),
        .push        (dec.push),
        .fresh       (dec.entry),
        .head        (head),
        .pop_ok      (pop_ok),
        .count_after (count_after)
    );

    // result word for the accepted command
    always_comb
    begin
        res.key_valid        = pop_ok;
        res.key_char         = pop_ok ? head.ch : 8'h00;
        res.key_scan         = pop_ok ? head.scan : 8'h00;
        res.key_pressed      = pop_ok ? head.pressed : 1'b0;
        res.fifo_count       = COUNT_W'(count_after);
        res.snapshot_saved   = dec.saved;
        res.snapshot_request = dec.snap_req;
    end

    // two-word output buffer
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept;
                out_next       = res;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_next = accept;
            out_next       = res;
        end
        else if (accept)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign evt_valid = out_valid_reg;
    assign evt       = out_reg;

    // checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without an output word");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> (evt.fifo_count <= COUNT_W'(FIFO_DEPTH)))
        else $error("queue count above depth");

    a_req_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt.snapshot_request) |-> evt.snapshot_saved)
        else $error("snapshot request without saved flag");

    a_pop_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt.key_valid) |-> (evt.key_pressed && evt.key_char != 8'h00))
        else $error("popped key without press flag or character");

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
    import skfd_pkg::*;

    localparam int QUEUE_DEPTH    = FIFO_DEPTH;
    localparam int WORK_ITEMS     = 1750;
    localparam int CALM_FROM      = 1550;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // character tables for make codes 00..39; every higher code maps to zero
    localparam logic [0:57][7:0] LOWER_TAB = {
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08,
        8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75,
        8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
        8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78,
        8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F,
        8'h00, 8'h2A, 8'h00, 8'h20
    };
    localparam logic [0:57][7:0] UPPER_TAB = {
        8'h00, 8'h1B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08,
        8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55,
        8'h49, 8'h4F, 8'h50, 8'h00, 8'h00, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
        8'h4C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5A, 8'h58,
        8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h20
    };

    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] scan;
    } key_word_t;

    typedef struct {
        cmd_t c;
        bit   typed;
        evt_t want;
    } table_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic evt_valid;
    logic evt_stall = 1'b0;
    evt_t evt;

    scancode_key_decoder_fifo_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

    // decoder shadow state
    logic      prefix_seen = 1'b0;
    logic      shift_down  = 1'b0;
    logic      caps_lock   = 1'b0;
    logic      snap_flag   = 1'b0;
    key_word_t key_q[$];

    evt_t       due_events[$];
    table_row_t table_rows[$];

    int  gap_pct    = 15;
    int  stall_pct  = 15;
    bit  calm       = 1'b0;
    int  mismatches = 0;
    int  words_in   = 0;
    int  words_out  = 0;
    int  key_pushes = 0;
    int  overwrites = 0;
    int  snap_pulses = 0;
    int  keys_popped = 0;
    int  empty_pops = 0;
    int  clears     = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic cmd_t mk_cmd(mode_t m, logic [7:0] b, logic en);
        cmd_t c;
        c.mode            = m;
        c.scan_byte       = b;
        c.snapshot_enable = en;
        return c;
    endfunction

    function automatic evt_t mk_evt(logic v, logic [7:0] ch, logic [7:0] sc,
                                    logic [COUNT_W-1:0] cnt, logic sv, logic rq);
        evt_t e;
        e.key_valid        = v;
        e.key_char         = ch;
        e.key_scan         = sc;
        e.key_pressed      = v;
        e.fifo_count       = cnt;
        e.snapshot_saved   = sv;
        e.snapshot_request = rq;
        return e;
    endfunction

    // queue a key; a full queue loses its oldest key
    function automatic void store_key(logic [7:0] ch, logic [7:0] code);
        if (key_q.size() >= QUEUE_DEPTH) begin
            void'(key_q.pop_front());
            overwrites++;
        end
        key_q.push_back(key_word_t'{ch, code});
        key_pushes++;
    endfunction

    // expected output word for one command, updating the shadow state
    function automatic evt_t decode_step(cmd_t c);
        evt_t       r;
        key_word_t  k;
        logic [7:0] b;
        logic [7:0] ch;
        r  = '0;
        b  = c.scan_byte;
        ch = 8'h00;
        case (c.mode)
            MODE_SCAN: begin
                if (b == SC_EXT)
                    prefix_seen = 1'b1;
                else if (prefix_seen) begin
                    // only arrow make codes survive the prefix
                    prefix_seen = 1'b0;
                    case (b)
                        SC_UP:    ch = TOK_UP;
                        SC_DOWN:  ch = TOK_DOWN;
                        SC_LEFT:  ch = TOK_LEFT;
                        SC_RIGHT: ch = TOK_RIGHT;
                        default:  ch = 8'h00;
                    endcase
                    if (ch != 8'h00)
                        store_key(ch, b);
                end
                else if (b == SC_LSHIFT || b == SC_RSHIFT)
                    shift_down = 1'b1;
                else if (b == SC_LSHIFT_BR || b == SC_RSHIFT_BR)
                    shift_down = 1'b0;
                else if (b == SC_CAPS)
                    caps_lock = ~caps_lock;
                else if (b == SC_TAB && shift_down && c.snapshot_enable) begin
                    snap_flag          = 1'b1;
                    r.snapshot_request = 1'b1;
                    snap_pulses++;
                end
                else if (!b[7]) begin
                    if (b < 8'd58)
                        ch = caps_lock ? UPPER_TAB[b[5:0]] : LOWER_TAB[b[5:0]];
                    if (ch != 8'h00)
                        store_key(ch, b);
                end
            end
            MODE_POP: begin
                if (key_q.size() > 0) begin
                    k             = key_q.pop_front();
                    r.key_valid   = 1'b1;
                    r.key_char    = k.ch;
                    r.key_scan    = k.scan;
                    r.key_pressed = 1'b1;
                    keys_popped++;
                end
                else
                    empty_pops++;
            end
            MODE_CLEAR: begin
                key_q.delete();
                clears++;
            end
            default: snap_flag = 1'b0;
        endcase
        r.fifo_count     = COUNT_W'(key_q.size());
        r.snapshot_saved = snap_flag;
        return r;
    endfunction

    task automatic add_row(input mode_t m, input logic [7:0] b, input logic en,
                           input bit typed, input evt_t want);
        table_row_t row;
        row.c     = mk_cmd(m, b, en);
        row.typed = typed;
        row.want  = want;
        table_rows.push_back(row);
    endtask

    // drive one command word, optionally after an idle burst
    task automatic send_word(input cmd_t c, input bit typed, input evt_t want);
        evt_t model_out;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        cmd       <= c;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        model_out = decode_step(c);
        due_events.push_back(typed ? want : model_out);
        words_in++;
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (due_events.size() != 0)
            @(posedge clk);
    endtask

    // receiver stall bursts
    int stall_left = 0;
    always @(posedge clk) begin
        if (!rst_n || calm) begin
            stall_left = 0;
            evt_stall <= 1'b0;
        end
        else if (stall_left > 0) begin
            stall_left--;
            evt_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 14) - 1;
            evt_stall <= 1'b1;
        end
        else
            evt_stall <= 1'b0;
    end

    // result checker
    always @(posedge clk) begin
        evt_t want;
        if (rst_n && evt_valid && !evt_stall) begin
            words_out++;
            if (due_events.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: output word with nothing expected: %h", $realtime, evt);
                mismatches++;
            end
            else begin
                want = due_events.pop_front();
                if (evt.key_valid !== want.key_valid || evt.key_char !== want.key_char
                    || evt.key_scan !== want.key_scan
                    || evt.key_pressed !== want.key_pressed
                    || evt.fifo_count !== want.fifo_count
                    || evt.snapshot_saved !== want.snapshot_saved
                    || evt.snapshot_request !== want.snapshot_request) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("%0t: word %0d mismatch", $realtime, words_out);
                        $display("  want v=%b ch=%h sc=%h p=%b cnt=%0d sv=%b rq=%b",
                                 want.key_valid, want.key_char, want.key_scan,
                                 want.key_pressed, want.fifo_count,
                                 want.snapshot_saved, want.snapshot_request);
                        $display("  got  v=%b ch=%h sc=%h p=%b cnt=%0d sv=%b rq=%b",
                                 evt.key_valid, evt.key_char, evt.key_scan,
                                 evt.key_pressed, evt.fifo_count,
                                 evt.snapshot_saved, evt.snapshot_request);
                    end
                    mismatches++;
                end
            end
        end
    end

    // watchdog: cycles in which no word moves on either side
    int quiet_cycles = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if ((cmd_valid && !cmd_stall) || (evt_valid && !evt_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles, %0d still expected",
                         quiet_cycles, due_events.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        cmd_t seq[2];
        int   seq_len;
        int   seg_len;
        int   pop_pct;
        int   pick;
        int   n;
        bit   paused;
        logic [7:0] arrow;
        paused = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        add_row(MODE_POP,      8'h00, 1'b0, 1'b1, mk_evt(0, 8'h00, 8'h00, 0, 0, 0));
        add_row(MODE_SCAN,     8'h00, 1'b1, 1'b1, mk_evt(0, 8'h00, 8'h00, 0, 0, 0));
        add_row(MODE_SCAN,     8'hFF, 1'b1, 1'b1, mk_evt(0, 8'h00, 8'h00, 0, 0, 0));
        add_row(MODE_SCAN,     8'h1E, 1'b0, 1'b1, mk_evt(0, 8'h00, 8'h00, 1, 0, 0));
        add_row(MODE_SCAN,     SC_CAPS, 1'b0, 1'b0, '0);
        add_row(MODE_SCAN,     8'h1E, 1'b0, 1'b0, '0);
        add_row(MODE_SCAN,     SC_CAPS, 1'b0, 1'b0, '0);
        add_row(MODE_SCAN,     SC_EXT, 1'b0, 1'b0, '0);
        add_row(MODE_SCAN,     SC_EXT, 1'b1, 1'b0, '0);
        add_row(MODE_SCAN,     SC_UP, 1'b0, 1'b0, '0);
        add_row(MODE_SCAN,     SC_EXT, 1'b0, 1'b0, '0);
        add_row(MODE_SCAN,     SC_DOWN, 1'b0, 1'b0, '0);
        add_row(MODE_SCAN,     SC_EXT, 1'b0, 1'b0, '0);
        add_row(MODE_SCAN,     SC_LEFT, 1'b1, 1'b0, '0);
        add_row(MODE_SCAN,     SC_EXT, 1'b0, 1'b0, '0);
        add_row(MODE_SCAN,     SC_RIGHT, 1'b0, 1'b0, '0);
        add_row(MODE_SCAN,     SC_EXT, 1'b0, 1'b0, '0);
        add_row(MODE_SCAN,     8'hC8, 1'b0, 1'b0, '0);
        add_row(MODE_SCAN,     SC_EXT, 1'b0, 1'b0, '0);
        add_row(MODE_SCAN,     8'h1E, 1'b0, 1'b0, '0);
        add_row(MODE_SCAN,     SC_RSHIFT, 1'b0, 1'b0, '0);
        add_row(MODE_SCAN,     SC_TAB, 1'b1, 1'b1, mk_evt(0, 8'h00, 8'h00, 6, 1, 1));
        add_row(MODE_SCAN,     SC_TAB, 1'b0, 1'b0, '0);
        add_row(MODE_SCAN,     SC_RSHIFT_BR, 1'b0, 1'b0, '0);
        add_row(MODE_FLAG_CLR, 8'hA5, 1'b1, 1'b1, mk_evt(0, 8'h00, 8'h00, 7, 0, 0));
        add_row(MODE_POP,      8'h5A, 1'b1, 1'b1, mk_evt(1, 8'h61, 8'h1E, 6, 0, 0));
        add_row(MODE_CLEAR,    8'hFF, 1'b1, 1'b1, mk_evt(0, 8'h00, 8'h00, 0, 0, 0));
        add_row(MODE_POP,      8'h00, 1'b0, 1'b1, mk_evt(0, 8'h00, 8'h00, 0, 0, 0));
        foreach (table_rows[i])
            send_word(table_rows[i].c, table_rows[i].typed, table_rows[i].want);
        wait_drained();

        // random segments with their own pop, gap and stall rates
        while (words_in < WORK_ITEMS) begin
            seg_len = $urandom_range(30, 120);
            case ($urandom_range(0, 2))
                0:       pop_pct = 3;
                1:       pop_pct = 25;
                default: pop_pct = 55;
            endcase
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 6;
                default: gap_pct = 25;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 6;
                default: stall_pct = 30;
            endcase
            if (words_in >= CALM_FROM) begin
                calm      = 1'b1;
                gap_pct   = 0;
                stall_pct = 0;
            end
            if (!paused && words_in >= WORK_ITEMS / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            for (n = 0; n < seg_len && words_in < WORK_ITEMS; n++) begin
                seq_len = 1;
                pick    = $urandom_range(0, 99);
                if (pick < pop_pct)
                    seq[0] = mk_cmd(MODE_POP, 8'($urandom), 1'($urandom));
                else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 55)
                        seq[0] = mk_cmd(MODE_SCAN, 8'($urandom_range(1, 57)), 1'($urandom));
                    else if (pick < 65) begin
                        // extended prefix then an arrow, sometimes a stray byte
                        case ($urandom_range(0, 3))
                            0:       arrow = SC_UP;
                            1:       arrow = SC_DOWN;
                            2:       arrow = SC_LEFT;
                            default: arrow = SC_RIGHT;
                        endcase
                        if ($urandom_range(0, 3) == 0)
                            arrow = 8'($urandom);
                        seq[0]  = mk_cmd(MODE_SCAN, SC_EXT, 1'($urandom));
                        seq[1]  = mk_cmd(MODE_SCAN, arrow, 1'($urandom));
                        seq_len = 2;
                    end
                    else if (pick < 72) begin
                        case ($urandom_range(0, 3))
                            0:       arrow = SC_LSHIFT;
                            1:       arrow = SC_RSHIFT;
                            2:       arrow = SC_LSHIFT_BR;
                            default: arrow = SC_RSHIFT_BR;
                        endcase
                        seq[0] = mk_cmd(MODE_SCAN, arrow, 1'($urandom));
                    end
                    else if (pick < 76)
                        seq[0] = mk_cmd(MODE_SCAN, SC_CAPS, 1'($urandom));
                    else if (pick < 83)
                        seq[0] = mk_cmd(MODE_SCAN, SC_TAB, 1'($urandom));
                    else if (pick < 88)
                        seq[0] = mk_cmd(MODE_FLAG_CLR, 8'($urandom), 1'($urandom));
                    else if (pick < 90)
                        seq[0] = mk_cmd(MODE_CLEAR, 8'($urandom), 1'($urandom));
                    else
                        seq[0] = mk_cmd(mode_t'($urandom_range(0, 3)), 8'($urandom),
                                        1'($urandom));
                end
                for (int j = 0; j < seq_len; j++)
                    send_word(seq[j], 1'b0, '0);
            end
        end

        // drain and let any stray word show up
        wait_drained();
        repeat (10) @(posedge clk);

        $display("%0d command words sent, %0d output words checked,", words_in, words_out);
        $display("%0d keys popped, %0d pops on empty, %0d keys queued,",
                 keys_popped, empty_pops, key_pushes);
        $display("%0d oldest-key overwrites, %0d snapshot pulses, %0d queue clears",
                 overwrites, snap_pulses, clears);
        if (mismatches == 0 && due_events.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
